FILE: rtl/mtmb_pkg.sv
// Shared types, constants and arithmetic helpers for the model transform matrix builder.
// No dependencies; imported by mtmb_cordic and model_transform_matrix_builder_core.
package mtmb_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int DEG_HALF_TURN   = 180;
    localparam int FULL_TURN       = (2 * DEG_HALF_TURN) << ANGLE_FRAC_BITS;

    // phase = floor(m * 2^32 / FULL_TURN) = m * PH_Q + floor(m * PH_NUM / PH_DEN)
    localparam int PH_Q       = 186413;
    localparam int PH_NUM     = 23;
    localparam int PH_DEN     = 45;
    // floor(x / PH_DEN) = (x * PH_RECIP) >> PH_RECIP_SH, exact for x < 2^20
    localparam int PH_RECIP    = 1491309;
    localparam int PH_RECIP_SH = 26;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;

    // angle reduction, phase multiply, phase sum, CORDIC steps, quadrant and rounding
    localparam int CS_LAT = 3 + CORDIC_STEPS + 1;
    // four product/sum stages plus round-and-saturate
    localparam int PIPE_DEPTH = CS_LAT + 5;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    typedef logic signed [17:0] trig_t;
    typedef logic signed [19:0] rot_t;

    typedef struct packed {
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] stretch_x;
        logic signed [31:0] stretch_y;
        logic signed [31:0] stretch_z;
    } item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } row_t;

    typedef struct packed {
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [31:0] stretch_x;
        logic signed [31:0] stretch_y;
        logic signed [31:0] stretch_z;
    } side_t;

    function automatic logic signed [32:0] atan_turn(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sh020000000;
            5'd1:    v = 33'sh012E4051D;
            5'd2:    v = 33'sh009FB385B;
            5'd3:    v = 33'sh0051111D4;
            5'd4:    v = 33'sh0028B0D43;
            5'd5:    v = 33'sh00145D7E1;
            5'd6:    v = 33'sh000A2F61E;
            5'd7:    v = 33'sh000517C55;
            5'd8:    v = 33'sh00028BE53;
            5'd9:    v = 33'sh000145F2E;
            5'd10:   v = 33'sh0000A2F98;
            5'd11:   v = 33'sh0000517CC;
            5'd12:   v = 33'sh000028BE6;
            5'd13:   v = 33'sh0000145F3;
            5'd14:   v = 33'sh00000A2F9;
            5'd15:   v = 33'sh00000517C;
            5'd16:   v = 33'sh0000028BE;
            5'd17:   v = 33'sh00000145F;
            5'd18:   v = 33'sh000000A2F;
            5'd19:   v = 33'sh000000517;
            5'd20:   v = 33'sh00000028B;
            5'd21:   v = 33'sh000000145;
            5'd22:   v = 33'sh0000000A2;
            5'd23:   v = 33'sh000000051;
            default: v = 33'sh000000000;
        endcase
        return v;
    endfunction

    // Fixed-point product with round half up: floor((a*b + 2^(F-1)) / 2^F)
    function automatic rot_t fx_mul20(input rot_t a, input rot_t b);
        logic signed [39:0] p;
        logic signed [39:0] r;
        p = a * b;
        r = (p + (40'sd1 <<< (VALUE_FRAC_BITS - 1))) >>> VALUE_FRAC_BITS;
        return r[19:0];
    endfunction

endpackage

FILE: rtl/model_transform_matrix_builder_core.sv
// Model matrix builder: T * Rz * Ry * Rx * S as three rows of Q16.16.
// Each item leaves as three row beats, so sustained item throughput is set by the
// single row channel.
// The whole pipeline holds while the finished matrix waits for its last row beat.
// Reset (rst_n, async, active low) clears valid bits and the row counter only.
// Depends on mtmb_pkg and mtmb_cordic.
module model_transform_matrix_builder_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mtmb_pkg::item_t  item,
    output logic             row_valid,
    input  logic             row_ready,
    output mtmb_pkg::row_t   row
);
    import mtmb_pkg::*;

    localparam int N = PIPE_DEPTH;
    // stage indices inside the pipeline (bit of valid_reg / entry of side_reg)
    localparam int IDX_M3 = CS_LAT + 2;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    side_t        side_reg [0:N-1];
    logic         adv;
    logic         last_take;
    logic [1:0]   row_reg;
    logic [1:0]   row_next;

    trig_t cx, sx, cy, sy, cz, sz;

    // first product level
    rot_t cycz_reg, czsx_reg, cxsz_reg, sxsz_reg, cxcz_reg, cysz_reg;
    rot_t sxsy_reg, cxsy_reg, cysx_reg, cxcy_reg, sy1_reg, sz1_reg;
    // second product level and carried terms
    rot_t t1_reg, t2_reg, t3_reg, t4_reg;
    rot_t cycz2_reg, cxsz2_reg, sxsz2_reg, cysz2_reg, cxcz2_reg, czsx2_reg;
    rot_t sy2_reg, cysx2_reg, cxcy2_reg;
    // rotation matrix, scaled products, final elements
    rot_t               rot_reg  [0:2][0:2];
    logic signed [51:0] prod_reg [0:2][0:2];
    logic signed [31:0] elem_reg [0:2][0:2];

    // Advance everything unless the output slot is full and not finishing now.
    assign last_take  = row_valid && row_ready && (row_reg == ROW_LAST);
    assign adv        = !valid_reg[N-1] || last_take;
    assign item_ready = adv;
    assign row_valid  = valid_reg[N-1];
    assign valid_next = {valid_reg[N-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    // Side payload (translation and scale) rides alongside the arithmetic.
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (k == 0)
                        side_reg[k] <= '{item.shift_x, item.shift_y, item.shift_z,
                                         item.stretch_x, item.stretch_y, item.stretch_z};
                    else
                        side_reg[k] <= side_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    mtmb_cordic u_trig_x (.clk(clk), .adv(adv), .angle(item.angle_x), .cos_val(cx), .sin_val(sx));
    mtmb_cordic u_trig_y (.clk(clk), .adv(adv), .angle(item.angle_y), .cos_val(cy), .sin_val(sy));
    mtmb_cordic u_trig_z (.clk(clk), .adv(adv), .angle(item.angle_z), .cos_val(cz), .sin_val(sz));

    // Pairwise products of sines and cosines.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cycz_reg <= fx_mul20(20'(cy), 20'(cz));
            czsx_reg <= fx_mul20(20'(cz), 20'(sx));
            cxsz_reg <= fx_mul20(20'(cx), 20'(sz));
            sxsz_reg <= fx_mul20(20'(sx), 20'(sz));
            cxcz_reg <= fx_mul20(20'(cx), 20'(cz));
            cysz_reg <= fx_mul20(20'(cy), 20'(sz));
            sxsy_reg <= fx_mul20(20'(sx), 20'(sy));
            cxsy_reg <= fx_mul20(20'(cx), 20'(sy));
            cysx_reg <= fx_mul20(20'(cy), 20'(sx));
            cxcy_reg <= fx_mul20(20'(cx), 20'(cy));
            sy1_reg  <= 20'(sy);
            sz1_reg  <= 20'(sz);
        end
    end

    // Third factor of the triple products; carry the rest.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg    <= fx_mul20(czsx_reg, sy1_reg);
            t2_reg    <= fx_mul20(cxcz_reg, sy1_reg);
            t3_reg    <= fx_mul20(sxsy_reg, sz1_reg);
            t4_reg    <= fx_mul20(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cxsz2_reg <= cxsz_reg;
            sxsz2_reg <= sxsz_reg;
            cysz2_reg <= cysz_reg;
            cxcz2_reg <= cxcz_reg;
            czsx2_reg <= czsx_reg;
            sy2_reg   <= sy1_reg;
            cysx2_reg <= cysx_reg;
            cxcy2_reg <= cxcy_reg;
        end
    end

    // Combine into the rotation matrix.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_reg[0][0] <= cycz2_reg;
            rot_reg[0][1] <= t1_reg - cxsz2_reg;
            rot_reg[0][2] <= sxsz2_reg + t2_reg;
            rot_reg[1][0] <= cysz2_reg;
            rot_reg[1][1] <= cxcz2_reg + t3_reg;
            rot_reg[1][2] <= t4_reg - czsx2_reg;
            rot_reg[2][0] <= -sy2_reg;
            rot_reg[2][1] <= cysx2_reg;
            rot_reg[2][2] <= cxcy2_reg;
        end
    end

    // Scale each column by its axis factor, then round and saturate.
    genvar r, c;
    generate
        for (r = 0; r < 3; r++)
        begin : g_row
            for (c = 0; c < 3; c++)
            begin : g_col
                logic signed [31:0] stretch;
                logic signed [51:0] rounded;
                logic signed [31:0] elem_next;
                assign stretch = (c == 0) ? side_reg[IDX_M3].stretch_x :
                                 (c == 1) ? side_reg[IDX_M3].stretch_y :
                                            side_reg[IDX_M3].stretch_z;
                assign rounded = (prod_reg[r][c] + (52'sd1 <<< (VALUE_FRAC_BITS - 1)))
                                 >>> VALUE_FRAC_BITS;
                always_comb
                begin
                    if (rounded > 52'sh0007FFFFFFF)
                        elem_next = 32'sh7FFFFFFF;
                    else if (rounded < -52'sh00080000000)
                        elem_next = 32'sh80000000;
                    else
                        elem_next = rounded[31:0];
                end
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        prod_reg[r][c] <= 52'(stretch) * 52'(rot_reg[r][c]);
                        elem_reg[r][c] <= elem_next;
                    end
                end
            end
        end
    endgenerate

    // Row counter: advance per row beat, drop back to the first row at the end.
    always_comb
    begin
        row_next = row_reg;
        if (row_valid && row_ready)
            row_next = (row_reg == ROW_LAST) ? ROW_FIRST : row_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= ROW_FIRST;
        else
            row_reg <= row_next;
    end

    always_comb
    begin
        row.row_index = row_reg;
        row.last_row  = (row_reg == ROW_LAST);
        case (row_reg)
            ROW_MID:
            begin
                row.col0 = elem_reg[1][0];
                row.col1 = elem_reg[1][1];
                row.col2 = elem_reg[1][2];
                row.col3 = side_reg[N-1].shift_y;
            end
            ROW_LAST:
            begin
                row.col0 = elem_reg[2][0];
                row.col1 = elem_reg[2][1];
                row.col2 = elem_reg[2][2];
                row.col3 = side_reg[N-1].shift_z;
            end
            default:
            begin
                row.col0 = elem_reg[0][0];
                row.col1 = elem_reg[0][1];
                row.col2 = elem_reg[0][2];
                row.col3 = side_reg[N-1].shift_x;
            end
        endcase
    end

    // The row counter never leaves rows 0..2.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg != 2'd3)
        else $error("row counter out of range");

    // Finishing the last row starts the next matrix at row 0.
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        last_take |=> (row_reg == ROW_FIRST))
        else $error("row counter did not wrap");

    // A held pipeline neither loses nor gains items.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("valid bits moved during a hold");

    // Row counter only moves while a matrix is present.
    a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !row_valid |=> $stable(row_reg))
        else $error("row counter moved with no matrix");

endmodule

FILE: rtl/mtmb_cordic.sv
// Pipelined sine/cosine for one Euler angle: wrap, phase scaling, 24 CORDIC steps.
// Depends on mtmb_pkg; every register advances only while adv is high.
module mtmb_cordic (
    input  logic                  clk,
    input  logic                  adv,
    input  logic signed [15:0]    angle,
    output mtmb_pkg::trig_t       cos_val,
    output mtmb_pkg::trig_t       sin_val
);
    import mtmb_pkg::*;

    logic [14:0]        m_reg;
    logic [14:0]        m_next;
    logic [31:0]        p1_reg;
    logic [40:0]        p2_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] x_reg [1:CORDIC_STEPS];
    logic signed [31:0] y_reg [1:CORDIC_STEPS];
    logic signed [32:0] z_reg [1:CORDIC_STEPS];
    logic [1:0]         quad_reg [1:CORDIC_STEPS];
    trig_t              cos_reg;
    trig_t              sin_reg;
    trig_t              cos_next;
    trig_t              sin_next;

    // Wrap into one turn; one or two corrections cover the 16-bit range.
    always_comb
    begin
        logic signed [17:0] a;
        a = 18'(angle);
        if (a < 0)
        begin
            a = a + 18'(FULL_TURN);
            if (a < 0)
                a = a + 18'(FULL_TURN);
        end
        else if (a >= 18'(FULL_TURN))
        begin
            a = a - 18'(FULL_TURN);
        end
        m_next = a[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg     <= m_next;
            p1_reg    <= 32'(m_reg * 32'(PH_Q));
            p2_reg    <= 41'(20'(m_reg * 20'(PH_NUM)) * 41'(PH_RECIP));
            phase_reg <= p1_reg + 32'(p2_reg >> PH_RECIP_SH);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [31:0] xs;
            logic signed [31:0] ys;
            logic signed [32:0] zs;
            logic [1:0]         qs;
            if (i == 0)
            begin : g_first
                assign xs = CORDIC_X0;
                assign ys = 32'sd0;
                assign zs = {3'b000, phase_reg[29:0]};
                assign qs = phase_reg[31:30];
            end
            else
            begin : g_rest
                assign xs = x_reg[i];
                assign ys = y_reg[i];
                assign zs = z_reg[i];
                assign qs = quad_reg[i];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!zs[32])
                    begin
                        x_reg[i+1] <= xs - (ys >>> i);
                        y_reg[i+1] <= ys + (xs >>> i);
                        z_reg[i+1] <= zs - atan_turn(5'(i));
                    end
                    else
                    begin
                        x_reg[i+1] <= xs + (ys >>> i);
                        y_reg[i+1] <= ys - (xs >>> i);
                        z_reg[i+1] <= zs + atan_turn(5'(i));
                    end
                    quad_reg[i+1] <= qs;
                end
            end
        end
    endgenerate

    function automatic trig_t trig_round(input logic signed [32:0] v);
        logic signed [32:0] r;
        r = (v + (33'sd1 <<< (29 - VALUE_FRAC_BITS))) >>> (30 - VALUE_FRAC_BITS);
        if (r > (33'sd1 <<< VALUE_FRAC_BITS))
            r = 33'sd1 <<< VALUE_FRAC_BITS;
        if (r < -(33'sd1 <<< VALUE_FRAC_BITS))
            r = -(33'sd1 <<< VALUE_FRAC_BITS);
        return r[17:0];
    endfunction

    // Rotate the pair by the quadrant, then round to the value format.
    always_comb
    begin
        logic signed [32:0] xc;
        logic signed [32:0] yc;
        logic signed [32:0] c;
        logic signed [32:0] s;
        xc = 33'(x_reg[CORDIC_STEPS]);
        yc = 33'(y_reg[CORDIC_STEPS]);
        case (quad_reg[CORDIC_STEPS])
            2'd1:    begin c = -yc; s = xc;  end
            2'd2:    begin c = -xc; s = -yc; end
            2'd3:    begin c = yc;  s = -xc; end
            default: begin c = xc;  s = yc;  end
        endcase
        cos_next = trig_round(c);
        sin_next = trig_round(s);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule
